### sv/fbvs_pkg.sv
// shared types and constants for the fabric bandwidth vote scaler
package fbvs_pkg;

    // field widths fixed by the item format
    localparam int VOTE_W     = 4;
    localparam int ROW_W      = 3 * VOTE_W;
    localparam int IDX_W      = 5;
    localparam int CNT_REG_W  = 6;
    localparam int PCT_W      = 16;
    localparam int WORD_W     = 16;
    localparam int IN_DATA_W  = 24;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // row layout: hbw 11:8, memss 7:4, gmc 3:0
    localparam int HBW_LSB   = 8;
    localparam int MEMSS_LSB = 4;
    localparam int GMC_LSB   = 0;
    localparam int VALID_BIT = 15;

    // rounding and divide-by-100 through a reciprocal multiply
    // ceil(2^27/100) is exact for every dividend below 2^20
    localparam int SUM_W       = VOTE_W + PCT_W;
    localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'(50);
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(1342178);
    localparam int RECIP_SHIFT = 27;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;

    // reset values of the registers
    localparam logic [CNT_REG_W-1:0] STATE_COUNT_RST = CNT_REG_W'(32);
    localparam logic [PCT_W-1:0]     VOTE_PCT_RST    = PCT_W'(100);

    typedef enum logic [0:0] {
        REG_STATE_COUNT = 1'b0,
        REG_VOTE_PCT    = 1'b1
    } t_reg_idx;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_VOTE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [CNT_REG_W-1:0] state_count;
        logic [PCT_W-1:0]     vote_pct;
    } t_cfg;

    // per-stage load enables for the scaling lanes
    typedef struct packed {
        logic s2;
        logic s3;
    } t_lane_en;

endpackage

### sv/fabric_bandwidth_vote_scaler_unit.sv
// top level of the fabric bandwidth vote scaler
// A table of three 4-bit bandwidth votes (hbw, memss, gmc) per performance
// state is kept in a small ram. Load beats (tuser 0) write one row and give no
// result; a load at or beyond the table depth is dropped. Vote beats (tuser 1)
// read the named row and the top configured row together; each vote is scaled
// as (v*p+50)/100 and clamped to the top row's vote in the same column, then
// packed into a 16-bit word with the valid bit at 15. A state index at or
// beyond the state count gives a zero word with the error flag set. The block
// takes one beat every clock and sustains one result per clock while the output
// is not stalled. A vote beat is read from the ram at the accepting edge, then
// passes through scale multiply, reciprocal multiply, and clamp and pack into
// the output register. Only the output handshake stalls the pipeline, and
// bubbles are squeezed out. Rows are undefined until loaded and need no
// clearing after reset; voting on a row, or with a top row, that was never
// loaded gives an undefined word. Registers must be written only while the
// block is idle; the block itself does not enforce this.
module fabric_bandwidth_vote_scaler_unit #(
    parameter int MAX_STATES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: state_index[4:0], hbw_entry[8:5], memss_entry[12:9], gmc_entry[16:13]
    input  logic [fbvs_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // tuser: opcode[0]
    input  logic                             i_s_axis_tuser,
    // master side
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: vote_word[15:0]
    output logic [fbvs_pkg::WORD_W-1:0]      o_m_axis_tdata,
    // tuser: index_error[0]
    output logic                             o_m_axis_tuser,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fbvs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fbvs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fbvs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    import fbvs_pkg::*;

    localparam int AW    = $clog2(MAX_STATES);
    localparam int CW    = $clog2(MAX_STATES + 1);
    // compare width covers the count register, the index and the depth
    localparam int CMP_W = (CW > CNT_REG_W) ? CW : CNT_REG_W;
    localparam logic [CMP_W-1:0] DEPTH_EXT = CMP_W'(MAX_STATES);

    t_cfg cfg;

    // input beat fields
    t_opcode          in_op;
    logic [IDX_W-1:0] in_idx;
    logic [ROW_W-1:0] in_row;
    logic             in_fire;
    logic             in_vote;
    logic             in_load;

    // index checks and row addresses
    logic [CMP_W-1:0] sc_ext;
    logic [CMP_W-1:0] count;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] top_ext;
    logic             idx_err;
    logic             load_ok;

    // ram read data, the payload of stage 1
    logic [ROW_W-1:0] row_q;
    logic [ROW_W-1:0] top_q;

    // pipeline control: valid and error flags per stage
    logic r_s1_valid, r_s1_err;
    logic r_s2_valid, r_s2_err;
    logic r_s3_valid, r_s3_err;
    logic r_s4_valid, r_s4_err;
    logic rdy1, rdy2, rdy3, rdy4;
    t_lane_en lane_en;

    // lane results and the output word
    logic [VOTE_W-1:0] hbw_res;
    logic [VOTE_W-1:0] memss_res;
    logic [VOTE_W-1:0] gmc_res;
    logic [WORD_W-1:0] r_out_data;
    logic [WORD_W-1:0] n_out_data;

    fbvs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // unpack the input beat
    assign in_op  = t_opcode'(i_s_axis_tuser);
    assign in_idx = i_s_axis_tdata[IDX_W-1:0];
    assign in_row = {i_s_axis_tdata[IDX_W +: VOTE_W],
                     i_s_axis_tdata[IDX_W+VOTE_W +: VOTE_W],
                     i_s_axis_tdata[IDX_W+2*VOTE_W +: VOTE_W]};

    assign in_fire = i_s_axis_tvalid & o_s_axis_tready;
    assign in_vote = in_fire & (in_op == OP_VOTE);
    assign in_load = in_fire & (in_op == OP_LOAD);

    // a count above the table depth acts as the depth
    assign sc_ext  = CMP_W'(cfg.state_count);
    assign count   = (sc_ext > DEPTH_EXT) ? DEPTH_EXT : sc_ext;
    assign idx_ext = CMP_W'(in_idx);
    assign idx_err = (idx_ext >= count);
    assign load_ok = (idx_ext < DEPTH_EXT);
    // top configured row gives the clamp limits; unused when count is zero
    assign top_ext = count - CMP_W'(1);

    // loads and votes hit the ram at the same point, so a vote always
    // sees every load accepted before it
    fbvs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_STATES)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (in_load & load_ok),
        .i_waddr   (idx_ext[AW-1:0]),
        .i_wdata   (in_row),
        .i_re      (in_vote),
        .i_raddr_a (idx_ext[AW-1:0]),
        .i_raddr_b (top_ext[AW-1:0]),
        .o_rdata_a (row_q),
        .o_rdata_b (top_q)
    );

    // a stage loads when it is empty or the stage after it moves
    assign rdy4 = ~r_s4_valid | i_m_axis_tready;
    assign rdy3 = ~r_s3_valid | rdy4;
    assign rdy2 = ~r_s2_valid | rdy3;
    assign rdy1 = ~r_s1_valid | rdy2;

    assign o_s_axis_tready = rdy1;
    assign lane_en.s2      = rdy2;
    assign lane_en.s3      = rdy3;

    fbvs_lane u_lane_hbw (
        .i_clk    (i_clk),
        .i_en     (lane_en),
        .i_pct    (cfg.vote_pct),
        .i_vote   (row_q[HBW_LSB +: VOTE_W]),
        .i_limit  (top_q[HBW_LSB +: VOTE_W]),
        .o_result (hbw_res)
    );

    fbvs_lane u_lane_memss (
        .i_clk    (i_clk),
        .i_en     (lane_en),
        .i_pct    (cfg.vote_pct),
        .i_vote   (row_q[MEMSS_LSB +: VOTE_W]),
        .i_limit  (top_q[MEMSS_LSB +: VOTE_W]),
        .o_result (memss_res)
    );

    fbvs_lane u_lane_gmc (
        .i_clk    (i_clk),
        .i_en     (lane_en),
        .i_pct    (cfg.vote_pct),
        .i_vote   (row_q[GMC_LSB +: VOTE_W]),
        .i_limit  (top_q[GMC_LSB +: VOTE_W]),
        .o_result (gmc_res)
    );

    // pack the vote word, zero on an index error
    always_comb begin
        n_out_data = '0;
        if (!r_s3_err) begin
            n_out_data[VALID_BIT]              = 1'b1;
            n_out_data[HBW_LSB +: VOTE_W]      = hbw_res;
            n_out_data[MEMSS_LSB +: VOTE_W]    = memss_res;
            n_out_data[GMC_LSB +: VOTE_W]      = gmc_res;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_valid <= in_vote;
            end
            if (rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (rdy4) begin
                r_s4_valid <= r_s3_valid;
            end
        end
    end

    // error flags and output word travel beside the lanes
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_err <= idx_err;
        end
        if (rdy2) begin
            r_s2_err <= r_s1_err;
        end
        if (rdy3) begin
            r_s3_err <= r_s2_err;
        end
        if (rdy4) begin
            r_s4_err   <= r_s3_err;
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_s4_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_s4_err;

    // a good word carries the valid bit, an error word does not
    a_valid_vs_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> (r_out_data[VALID_BIT] != r_s4_err))
        else $error("vote word valid bit disagrees with index error");

    // reserved bits of the word stay zero
    a_reserved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> (r_out_data[VALID_BIT-1:HBW_LSB+VOTE_W] == '0))
        else $error("reserved bits of vote word set");

    // a load beat never enters the result pipeline
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_load |=> !r_s1_valid)
        else $error("load beat produced a pipeline entry");

    // a stalled output keeps the beat queued behind it
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_valid && !i_m_axis_tready && r_s3_valid) |=> r_s3_valid)
        else $error("beat lost behind stalled output");

    // an error word is all zeros
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_valid && r_s4_err) |-> (r_out_data == '0))
        else $error("index error with nonzero vote word");

endmodule

### sv/fbvs_ram.sv
// generic ram: one write port, two registered read ports
module fbvs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### sv/fbvs_cfg.sv
// apb register file: state count and scale percentage
module fbvs_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fbvs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fbvs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fbvs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output fbvs_pkg::t_cfg                   o_cfg
);

    import fbvs_pkg::*;

    logic [CNT_REG_W-1:0] r_state_count;
    logic [CNT_REG_W-1:0] n_state_count;
    logic [PCT_W-1:0]     r_vote_pct;
    logic [PCT_W-1:0]     n_vote_pct;
    logic                 wr_fire;
    t_reg_idx             reg_idx;

    assign pready  = 1'b1;
    assign wr_fire = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        n_state_count = r_state_count;
        n_vote_pct    = r_vote_pct;
        prdata        = '0;
        case (reg_idx)
            REG_STATE_COUNT: begin
                prdata = APB_DATA_W'(r_state_count);
                if (wr_fire) begin
                    n_state_count = pwdata[CNT_REG_W-1:0];
                end
            end
            REG_VOTE_PCT: begin
                prdata = APB_DATA_W'(r_vote_pct);
                if (wr_fire) begin
                    n_vote_pct = pwdata[PCT_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count <= STATE_COUNT_RST;
            r_vote_pct    <= VOTE_PCT_RST;
        end else begin
            r_state_count <= n_state_count;
            r_vote_pct    <= n_vote_pct;
        end
    end

    assign o_cfg.state_count = r_state_count;
    assign o_cfg.vote_pct    = r_vote_pct;

endmodule

### sv/fbvs_lane.sv
// one vote lane: scale, round, divide by 100 and clamp
module fbvs_lane (
    input  logic                         i_clk,
    input  fbvs_pkg::t_lane_en           i_en,
    input  logic [fbvs_pkg::PCT_W-1:0]   i_pct,
    input  logic [fbvs_pkg::VOTE_W-1:0]  i_vote,
    input  logic [fbvs_pkg::VOTE_W-1:0]  i_limit,
    output logic [fbvs_pkg::VOTE_W-1:0]  o_result
);

    import fbvs_pkg::*;

    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic [VOTE_W-1:0] r_lim2;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic [VOTE_W-1:0] r_lim3;
    logic [QUO_W-1:0]  quo;

    // v*p + 50
    assign n_sum = SUM_W'(i_vote) * SUM_W'(i_pct) + ROUND_ADD;
    // reciprocal multiply, quotient is the top bits
    assign n_prod = PROD_W'(r_sum) * PROD_W'(RECIP_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_sum  <= n_sum;
            r_lim2 <= i_limit;
        end
        if (i_en.s3) begin
            r_prod <= n_prod;
            r_lim3 <= r_lim2;
        end
    end

    assign quo      = r_prod[PROD_W-1:RECIP_SHIFT];
    assign o_result = (quo > QUO_W'(r_lim3)) ? r_lim3 : quo[VOTE_W-1:0];

endmodule

### tb/testbench.sv
// self-checking testbench for the fabric bandwidth vote scaler unit
`timescale 1ns / 1ps

module testbench;
    import fbvs_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 10;      // pipeline is four deep, give it some slack
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TABLE_DEPTH   = 32;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASES        = 5;
    localparam int PRINT_CAP     = 200;     // keep the log short when things go badly

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              err;
    } t_vote_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // tdata: state_index[4:0], hbw_entry[8:5], memss_entry[12:9], gmc_entry[16:13]
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // tuser: opcode[0]
    logic                  i_s_axis_tuser = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // tdata: vote_word[15:0]
    logic [WORD_W-1:0]     o_m_axis_tdata;
    // tuser: index_error[0]
    logic                  o_m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // mirror of the block: table, which rows hold data, and both registers
    logic [ROW_W-1:0]      vote_rows [TABLE_DEPTH];
    bit                    row_loaded [TABLE_DEPTH];
    logic [CNT_REG_W-1:0]  cfg_count = STATE_COUNT_RST;
    logic [PCT_W-1:0]      cfg_pct = VOTE_PCT_RST;

    t_vote_result          expected_votes [$];
    int                    mismatches = 0;
    int                    cycle_count = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;

    fabric_bandwidth_vote_scaler_unit #(
        .MAX_STATES(TABLE_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    endtask

    // state count above the table depth acts as the full table
    function automatic int unsigned eff_count();
        return (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_count);
    endfunction

    // scale by the percentage and round to nearest, then clamp to the top-state vote
    function automatic logic [VOTE_W-1:0] scale_vote(logic [VOTE_W-1:0] v,
                                                     logic [VOTE_W-1:0] cap);
        int unsigned q;
        q = (32'(v) * 32'(cfg_pct) + 32'd50) / 32'd100;
        if (q > 32'(cap))
            return cap;
        return q[VOTE_W-1:0];
    endfunction

    function automatic t_vote_result predict_vote(logic [IDX_W-1:0] idx);
        t_vote_result     r;
        int unsigned      cnt;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] top;
        cnt = eff_count();
        if (32'(idx) >= cnt) begin
            r.word = '0;
            r.err  = 1'b1;
            return r;
        end
        row = vote_rows[idx];
        top = vote_rows[cnt - 1];
        r.word = {1'b1, 3'b000,
                  scale_vote(row[HBW_LSB +: VOTE_W],   top[HBW_LSB +: VOTE_W]),
                  scale_vote(row[MEMSS_LSB +: VOTE_W], top[MEMSS_LSB +: VOTE_W]),
                  scale_vote(row[GMC_LSB +: VOTE_W],   top[GMC_LSB +: VOTE_W])};
        r.err  = 1'b0;
        return r;
    endfunction

    // result checker: every accepted beat against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_vote_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_votes.size() == 0) begin
                report_mismatch("vote beat with nothing pending", 32'(o_m_axis_tdata), '0);
            end else begin
                want = expected_votes.pop_front();
                if (o_m_axis_tdata !== want.word)
                    report_mismatch("vote_word", 32'(o_m_axis_tdata), 32'(want.word));
                if (o_m_axis_tuser !== want.err)
                    report_mismatch("index_error", 32'(o_m_axis_tuser), 32'(want.err));
            end
        end
    end

    // sends one beat; entered and left at a falling edge, tvalid left high
    task automatic send_item(t_opcode op, logic [IDX_W-1:0] idx,
                             logic [VOTE_W-1:0] hbw, logic [VOTE_W-1:0] memss,
                             logic [VOTE_W-1:0] gmc);
        logic [IN_DATA_W-1:0] d;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        d        = '0;
        d[4:0]   = idx;
        d[8:5]   = hbw;
        d[12:9]  = memss;
        d[16:13] = gmc;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        // beat accepted at this edge, update the mirror in order
        if (op == OP_LOAD) begin
            vote_rows[idx]  = {hbw, memss, gmc};
            row_loaded[idx] = 1'b1;
        end else begin
            expected_votes.push_back(predict_vote(idx));
        end
        @(negedge i_clk);
    endtask

    task automatic load_row(logic [IDX_W-1:0] idx, logic [VOTE_W-1:0] hbw,
                            logic [VOTE_W-1:0] memss, logic [VOTE_W-1:0] gmc);
        send_item(OP_LOAD, idx, hbw, memss, gmc);
    endtask

    // vote beats carry random entries, the block must ignore them
    task automatic vote(logic [IDX_W-1:0] idx);
        send_item(OP_VOTE, idx, VOTE_W'($urandom), VOTE_W'($urandom), VOTE_W'($urandom));
    endtask

    // hold the sender until every pending vote has come back
    task automatic wait_votes_done();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_votes.size() != 0);
    endtask

    // wait for the pending votes, then let the sender idle for SETTLE_CYCLES
    task automatic settle_idle();
        wait_votes_done();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_check(t_reg_idx r, logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(4 * int'(r));
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        if (got !== want)
            report_mismatch(r.name(), got, want);
    endtask

    // the read-back starts its setup phase right after the write access
    task automatic apb_write(t_reg_idx r, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(r));
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (r)
            REG_STATE_COUNT: begin
                cfg_count = value[CNT_REG_W-1:0];
            end
            REG_VOTE_PCT: begin
                cfg_pct = value[PCT_W-1:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        // read back what was just written
        apb_check(r, (r == REG_STATE_COUNT) ? APB_DATA_W'(cfg_count) : APB_DATA_W'(cfg_pct));
    endtask

    task automatic set_config(int unsigned cnt, int unsigned pct);
        settle_idle();
        apb_write(REG_STATE_COUNT, APB_DATA_W'(cnt));
        apb_write(REG_VOTE_PCT, APB_DATA_W'(pct));
    endtask

    // reset values, plain loads and votes, overwrite right before a vote
    task automatic test_reset_defaults();
        apb_check(REG_STATE_COUNT, APB_DATA_W'(STATE_COUNT_RST));
        apb_check(REG_VOTE_PCT, APB_DATA_W'(VOTE_PCT_RST));
        load_row(5'd31, 4'hF, 4'hF, 4'hF);
        load_row(5'd0, 4'h0, 4'h0, 4'h0);
        vote(5'd0);
        vote(5'd31);
        load_row(5'd7, 4'hA, 4'h5, 4'h3);
        vote(5'd7);
        load_row(5'd7, 4'h1, 4'h2, 4'h4);
        vote(5'd7);
    endtask

    // zero and full percentages, index error, clamping, rounding edge,
    // zero state count, oversized state count, single state
    task automatic test_config_extremes();
        set_config(4, 0);
        load_row(5'd3, 4'hF, 4'hF, 4'hF);
        vote(5'd3);
        vote(5'd4);
        vote(5'd31);
        set_config(4, 65535);
        load_row(5'd3, 4'h3, 4'h7, 4'hC);
        load_row(5'd1, 4'h1, 4'h8, 4'hF);
        vote(5'd1);
        vote(5'd0);
        // 1*49 rounds down to zero, 1*50 rounds up to one
        set_config(4, 49);
        vote(5'd1);
        set_config(4, 50);
        vote(5'd1);
        set_config(0, 100);
        vote(5'd0);
        set_config(63, 100);
        vote(5'd31);
        vote(5'd7);
        set_config(1, 250);
        vote(5'd0);
        vote(5'd1);
    endtask

    // one setting of the registers followed by a stream of mixed beats
    task automatic run_random_phase(int p);
        int unsigned      cnt;
        int unsigned      pct;
        int unsigned      eff;
        logic [IDX_W-1:0] idx;
        bit               is_load;
        case (p % PHASES)
            0: begin
                cnt = 32;
                pct = $urandom_range(200);
            end
            1: begin
                cnt = 63;
                pct = 65535;
            end
            2: begin
                cnt = 1;
                pct = 0;
            end
            3: begin
                cnt = $urandom_range(31, 2);
                pct = $urandom_range(65535);
            end
            default: begin
                cnt = $urandom_range(63);
                pct = $urandom_range(300);
            end
        endcase
        set_config(cnt, pct);
        eff = eff_count();
        // the top row supplies the clamp, it must hold data before any vote
        if (eff > 0)
            load_row(IDX_W'(eff - 1), VOTE_W'($urandom), VOTE_W'($urandom),
                     VOTE_W'($urandom));
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2 || $urandom_range(199) == 0)
                wait_votes_done();
            is_load = ($urandom_range(99) < 35);
            if (!is_load && eff > 0 && $urandom_range(99) < 75)
                idx = IDX_W'($urandom_range(eff - 1));
            else
                idx = IDX_W'($urandom);
            // never vote on a row below the count that holds no data, load it instead
            if (!is_load && 32'(idx) < eff && !row_loaded[idx])
                is_load = 1'b1;
            if (is_load)
                load_row(idx, VOTE_W'($urandom), VOTE_W'($urandom), VOTE_W'($urandom));
            else
                vote(idx);
        end
    endtask

    task automatic test_random_traffic(int sender_idle, int receiver_stall);
        send_idle_pct  = sender_idle;
        recv_stall_pct = receiver_stall;
        for (int p = 0; p < PHASES; p++)
            run_random_phase(p);
    endtask

    initial begin
        foreach (row_loaded[k])
            row_loaded[k] = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct  = 26;
        recv_stall_pct = 60;
        test_reset_defaults();
        test_config_extremes();

        test_random_traffic(26, 60);
        test_random_traffic(60, 26);
        test_random_traffic(0, 0);

        settle_idle();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
sv/fbvs_pkg.sv
sv/fbvs_ram.sv
sv/fbvs_cfg.sv
sv/fbvs_lane.sv
sv/fabric_bandwidth_vote_scaler_unit.sv
tb/testbench.sv
